/* rtl/core/alr_pkg.sv */
// Shared widths, register indexes and the segment entry type of the line rasterizer.
package alr_pkg;

  localparam int COORD_W = 6;
  localparam int POS_W = 7;
  localparam int LEVEL_W = 8;
  localparam int COUNT_W = 6;

  localparam int COORD_BITS_DEFAULT = 6;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_INDEX_LSB = 2;
  localparam logic REG_COUNT_STEPS_MODE = 1'b0;

  localparam int LEVEL_MAX = 255;

  typedef struct packed {
    logic               swapped;
    logic [COORD_W-1:0] maj_begin;
    logic [COORD_W-1:0] maj_end;
    logic [COORD_W-1:0] min_begin;
    logic [COORD_W-1:0] min_end;
    logic [COORD_W-1:0] dmaj;
    logic               dmin_neg;
    logic [COORD_W-1:0] dmin_mag;
  } seg_entry_t;

endpackage

/* rtl/core/alr_ifs.sv */
// Handshake channels for segments in and pixel results out.
interface alr_seg_if;
  logic                       valid;
  logic                       ready;
  logic [alr_pkg::COORD_W-1:0] x_begin;
  logic [alr_pkg::COORD_W-1:0] y_begin;
  logic [alr_pkg::COORD_W-1:0] x_end;
  logic [alr_pkg::COORD_W-1:0] y_end;

  modport source (output valid, output x_begin, output y_begin, output x_end, output y_end,
                  input ready);
  modport sink (input valid, input x_begin, input y_begin, input x_end, input y_end,
                output ready);
endinterface

interface alr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [alr_pkg::POS_W-1:0]   main_x;
  logic [alr_pkg::POS_W-1:0]   main_y;
  logic [alr_pkg::LEVEL_W-1:0] main_level;
  logic [alr_pkg::POS_W-1:0]   near_x;
  logic [alr_pkg::POS_W-1:0]   near_y;
  logic [alr_pkg::LEVEL_W-1:0] near_level;
  logic [alr_pkg::COUNT_W-1:0] step_count;
  logic                        last;

  modport source (output valid, output main_x, output main_y, output main_level,
                  output near_x, output near_y, output near_level, output step_count,
                  output last, input ready);
  modport sink (input valid, input main_x, input main_y, input main_level,
                input near_x, input near_y, input near_level, input step_count,
                input last, output ready);
endinterface

/* rtl/core/antialiased_line_rasterizer.sv */
// Top level of the antialiased line rasterizer: APB mode register, front end, queue, back end.
//
//   channel   direction  payload                                    handshake
//   seg       in         x_begin y_begin x_end y_end                valid/ready
//   pix       out        main_x/y/level near_x/y/level step_count   valid/ready
//                        last
//   apb       in/out     count_steps_mode at byte address 0         psel/penable/pready
//
// Per segment the back end pops it from the queue, runs the bit-serial slope divider and
// sets up the accumulator, then gives one result per cycle while the output is free in
// draw mode (dx+1 results, at least 2), or in count mode steps max(dx-1, 0) interior
// columns and then gives one result. The divider and the one-column stepper set its run time.
// Reset (rst, synchronous) clears the queue, the back-end state and output valid,
// and the mode register. A stalled result holds in the output register; the queue
// keeps taking segments from the front end while the back end is busy.
module antialiased_line_rasterizer #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEFAULT,
  parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = alr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  alr_seg_if.sink                        seg,
  alr_pix_if.source                      pix,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [alr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [alr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [alr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int DW = alr_pkg::APB_DATA_W;

  logic                count_mode;
  logic                reg_sel;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  alr_pkg::seg_entry_t q_in;
  alr_pkg::seg_entry_t q_out;

  // Decode on the word index only; the byte-offset bits are don't-care.
  assign reg_sel = paddr[alr_pkg::REG_INDEX_LSB] == alr_pkg::REG_COUNT_STEPS_MODE;
  assign pready = 1'b1;
  assign prdata = reg_sel ? DW'(count_mode) : '0;

  // Users change mode only while the block is idle (unchecked); back end reads it directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode <= 1'b0;
    end else if (psel && penable && pwrite && reg_sel) begin
      count_mode <= pwdata[0];
    end
  end

  // Front: classify the segment and push it into the queue.
  alr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .seg    (seg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // Queue: decouple segment intake from column generation.
  alr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back: divide for the slope, then step the accumulator column by column.
  alr_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .count_mode (count_mode),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .pix        (pix)
  );

endmodule

/* rtl/core/alr_front.sv */
// Front end: accept a segment, pick the major axis and order the endpoints.
module alr_front #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEFAULT
) (
  alr_seg_if.sink              seg,
  input  logic                 q_full,
  output logic                 q_push,
  output alr_pkg::seg_entry_t  q_data
);

  localparam int CW = alr_pkg::COORD_W;

  logic [COORD_BITS-1:0] xa, ya, xb, yb;
  logic [COORD_BITS-1:0] adx, ady;
  logic [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min;
  logic [COORD_BITS-1:0] maj_begin, maj_end, min_begin, min_end;
  logic                  swapped;

  assign seg.ready = !q_full;
  assign q_push = seg.valid && !q_full;

  always_comb begin
    xa = seg.x_begin[COORD_BITS-1:0];
    ya = seg.y_begin[COORD_BITS-1:0];
    xb = seg.x_end[COORD_BITS-1:0];
    yb = seg.y_end[COORD_BITS-1:0];
    adx = (xb > xa) ? xb - xa : xa - xb;
    ady = (yb > ya) ? yb - ya : ya - yb;
    swapped = ady > adx;
    // steep: walk along y
    a_maj = swapped ? ya : xa;
    a_min = swapped ? xa : ya;
    b_maj = swapped ? yb : xb;
    b_min = swapped ? xb : yb;
    if (a_maj > b_maj) begin
      maj_begin = b_maj;
      min_begin = b_min;
      maj_end = a_maj;
      min_end = a_min;
    end else begin
      maj_begin = a_maj;
      min_begin = a_min;
      maj_end = b_maj;
      min_end = b_min;
    end
    q_data.swapped = swapped;
    q_data.maj_begin = CW'(maj_begin);
    q_data.maj_end = CW'(maj_end);
    q_data.min_begin = CW'(min_begin);
    q_data.min_end = CW'(min_end);
    q_data.dmaj = CW'(maj_end - maj_begin);
    q_data.dmin_neg = min_end < min_begin;
    q_data.dmin_mag = (min_end < min_begin) ? CW'(min_begin - min_end)
                                            : CW'(min_end - min_begin);
  end

endmodule

/* rtl/core/alr_queue.sv */
// Short queue of classified segments between the front and back ends.
module alr_queue #(
  parameter int DEPTH = alr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  alr_pkg::seg_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output alr_pkg::seg_entry_t pop_data,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  alr_pkg::seg_entry_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full = fill == FILL_W'(DEPTH);
  assign empty = fill == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH)) else $error("queue fill beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty)) else $error("pop from empty queue");
`endif

endmodule

/* rtl/core/alr_back.sv */
// Back end: bit-serial slope divide, then one column result per cycle unless the output stalls, or a step count.
module alr_back #(
  parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                count_mode,
  input  logic                q_empty,
  input  alr_pkg::seg_entry_t q_data,
  output logic                q_pop,
  alr_pix_if.source           pix
);

  localparam int F = FRAC_BITS;
  localparam int CW = alr_pkg::COORD_W;
  localparam int PW = alr_pkg::POS_W;
  localparam int LW = alr_pkg::LEVEL_W;
  localparam int NW = alr_pkg::COUNT_W;
  localparam int ACC_W = F + 8;
  localparam int CNT_W = $clog2(F + 1);
  localparam logic signed [ACC_W-1:0] ONE_FIX = {{(ACC_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [LW-1:0] END_MAIN_LEVEL = LW'(alr_pkg::LEVEL_MAX / 2);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SETUP, S_END_A, S_END_B, S_COL, S_CNT
  } state_t;

  state_t              state;
  alr_pkg::seg_entry_t ent;
  logic [F:0]          quo;
  logic [CW-1:0]       rem;
  logic [CNT_W-1:0]    div_cnt;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] slope;
  logic [CW:0]         col;
  logic [CW:0]         steps;

  logic                out_free;
  logic                q0;
  logic [CW-1:0]       rem_init;
  logic [CW:0]         rem_dbl;
  logic                div_bit;
  logic [CW-1:0]       rem_step;
  logic signed [ACC_W-1:0] slope_next;
  logic signed [ACC_W-1:0] acc_start;
  logic signed [ACC_W-1:0] acc_sum;
  logic [CW:0]         maj_end_ext;
  logic                col_more;
  logic                col_last;
  logic [F-1:0]        frac;
  logic [F:0]          inv_frac;
  logic [F+8:0]        prod_main;
  logic [F+7:0]        prod_near;
  logic                emit_do;
  logic                emit_count;
  logic [PW-1:0]       em_maj;
  logic [PW-1:0]       em_min;
  logic [PW-1:0]       em_min1;
  logic [LW-1:0]       em_main_lvl;
  logic [LW-1:0]       em_near_lvl;
  logic                em_last;

  assign out_free = !pix.valid || pix.ready;
  assign q_pop = (state == S_IDLE) && !q_empty;

  always_comb begin
    q0 = q_data.dmin_mag >= q_data.dmaj;
    rem_init = q0 ? q_data.dmin_mag - q_data.dmaj : q_data.dmin_mag;
    rem_dbl = {rem, 1'b0};
    div_bit = rem_dbl >= {1'b0, ent.dmaj};
    rem_step = div_bit ? CW'(rem_dbl - {1'b0, ent.dmaj}) : CW'(rem_dbl);

    // ceil for rising lines, truncate toward zero for falling ones
    if (ent.dmaj == '0) begin
      slope_next = ONE_FIX;
    end else if (ent.dmin_neg) begin
      slope_next = -$signed(ACC_W'(quo));
    end else begin
      slope_next = $signed(ACC_W'(quo) + ACC_W'(rem != '0));
    end
    acc_start = $signed({{(ACC_W-CW-F){1'b0}}, ent.min_begin, {F{1'b0}}}) + slope_next;
    acc_sum = acc + slope;

    maj_end_ext = {1'b0, ent.maj_end};
    col_more = col < maj_end_ext;
    col_last = (col + (CW+1)'(1)) == maj_end_ext;

    frac = acc[F-1:0];
    inv_frac = {1'b1, {F{1'b0}}} - {1'b0, frac};
    prod_main = (F+9)'(inv_frac) * (F+9)'(alr_pkg::LEVEL_MAX);
    prod_near = (F+8)'(frac) * (F+8)'(alr_pkg::LEVEL_MAX);

    emit_count = 1'b0;
    em_maj = '0;
    em_min = '0;
    em_main_lvl = '0;
    em_near_lvl = '0;
    em_last = 1'b0;
    emit_do = 1'b0;
    case (state)
      S_END_A: begin
        emit_do = out_free;
        em_maj = PW'(ent.maj_begin);
        em_min = PW'(ent.min_begin);
        em_main_lvl = END_MAIN_LEVEL;
        em_last = ent.dmaj <= CW'(1);
      end
      S_END_B: begin
        emit_do = out_free;
        em_maj = PW'(ent.maj_end);
        em_min = PW'(ent.min_end);
        em_main_lvl = END_MAIN_LEVEL;
        em_last = ent.dmaj <= CW'(1);
      end
      S_COL: begin
        emit_do = out_free;
        em_maj = PW'(col);
        em_min = acc[F+PW-1:F];
        em_main_lvl = prod_main[F+7:F];
        em_near_lvl = prod_near[F+7:F];
        em_last = col_last;
      end
      S_CNT: begin
        emit_do = out_free && !col_more;
        emit_count = 1'b1;
        em_last = 1'b1;
      end
      default: begin
        emit_do = 1'b0;
      end
    endcase
    em_min1 = em_min + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pix.valid <= 1'b0;
    end else begin
      if (emit_do) begin
        pix.valid <= 1'b1;
      end else if (pix.valid && pix.ready) begin
        pix.valid <= 1'b0;
      end
      if (emit_do) begin
        pix.last <= em_last;
        if (emit_count) begin
          pix.main_x <= '0;
          pix.main_y <= '0;
          pix.near_x <= '0;
          pix.near_y <= '0;
          pix.main_level <= '0;
          pix.near_level <= '0;
          pix.step_count <= steps[NW-1:0];
        end else begin
          pix.main_x <= ent.swapped ? em_min : em_maj;
          pix.main_y <= ent.swapped ? em_maj : em_min;
          pix.near_x <= ent.swapped ? em_min1 : em_maj;
          pix.near_y <= ent.swapped ? em_maj : em_min1;
          pix.main_level <= em_main_lvl;
          pix.near_level <= em_near_lvl;
          pix.step_count <= '0;
        end
      end

      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            ent <= q_data;
            quo <= {{F{1'b0}}, q0};
            rem <= rem_init;
            div_cnt <= CNT_W'(F);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quo <= {quo[F-1:0], div_bit};
          rem <= rem_step;
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == CNT_W'(1)) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          slope <= slope_next;
          acc <= acc_start;
          col <= {1'b0, ent.maj_begin} + (CW+1)'(1);
          steps <= '0;
          state <= count_mode ? S_CNT : S_END_A;
        end
        S_END_A: begin
          if (out_free) begin
            state <= S_END_B;
          end
        end
        S_END_B: begin
          if (out_free) begin
            state <= (ent.dmaj <= CW'(1)) ? S_IDLE : S_COL;
          end
        end
        S_COL: begin
          if (out_free) begin
            acc <= acc_sum;
            col <= col + (CW+1)'(1);
            if (col_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_CNT: begin
          if (col_more) begin
            steps <= steps + (CW+1)'(acc[ACC_W-1:F] != acc_sum[ACC_W-1:F]);
            acc <= acc_sum;
            col <= col + (CW+1)'(1);
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt != '0)) else $error("divider ran past its last bit");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && ent.dmaj != '0) |-> (rem < ent.dmaj))
    else $error("divider remainder not below divisor");
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_COL) |-> (col < {1'b0, ent.maj_end}))
    else $error("interior column reached the end column");
`endif

endmodule

/* test/tb_antialiased_line_rasterizer.sv */
// Self-checking testbench for the antialiased line rasterizer: segments in, pixels checked out.
`timescale 1ns / 100ps

module tb_antialiased_line_rasterizer;

  localparam int COORD_W = alr_pkg::COORD_W;
  localparam int POS_W = alr_pkg::POS_W;
  localparam int LEVEL_W = alr_pkg::LEVEL_W;
  localparam int COUNT_W = alr_pkg::COUNT_W;
  localparam int APB_ADDR_W = alr_pkg::APB_ADDR_W;
  localparam int APB_DATA_W = alr_pkg::APB_DATA_W;
  localparam int LEVEL_MAX = alr_pkg::LEVEL_MAX;
  localparam int FRAC = alr_pkg::FRAC_BITS_DEFAULT;
  localparam longint ONE_FX = longint'(1) << FRAC;
  localparam longint FRAC_MASK = ONE_FX - 1;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam logic [APB_ADDR_W-1:0] MODE_ADDR =
    APB_ADDR_W'(int'(alr_pkg::REG_COUNT_STEPS_MODE) << alr_pkg::REG_INDEX_LSB);

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 60;
  localparam int HOLD_CYCLES = 400;
  // Divider, setup and the longest column run, with margin for a stray late result.
  localparam int SETTLE_CYCLES = FRAC + 2 * 64;

  typedef enum bit {MODE_DRAW = 1'b0, MODE_COUNT = 1'b1} mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_begin;
    logic [COORD_W-1:0] y_begin;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
  } seg_t;

  typedef struct packed {
    logic [POS_W-1:0]   main_x;
    logic [POS_W-1:0]   main_y;
    logic [LEVEL_W-1:0] main_level;
    logic [POS_W-1:0]   near_x;
    logic [POS_W-1:0]   near_y;
    logic [LEVEL_W-1:0] near_level;
    logic [COUNT_W-1:0] step_count;
    logic               last;
  } pix_t;

  typedef pix_t pix_q_t[$];

  // One directed row: the mode it runs in, the segment, and, where the answer is
  // obvious, how many copies of a hand-written result to expect instead of the predictor.
  typedef struct packed {
    mode_t      mode;
    seg_t       seg;
    logic [1:0] typed_count;
    pix_t       typed;
  } stim_row_t;

  localparam stim_row_t DIRECTED [21] = '{
    // Draw mode. Coincident endpoints give two identical endpoint results.
    '{MODE_DRAW,  '{0, 0, 0, 0},     2, '{0, 0, 127, 0, 1, 0, 0, 1}},
    '{MODE_DRAW,  '{63, 63, 63, 63}, 2, '{63, 63, 127, 63, 64, 0, 0, 1}},
    '{MODE_DRAW,  '{0, 0, 63, 0},    0, '0},  // full-width horizontal
    '{MODE_DRAW,  '{0, 0, 0, 63},    0, '0},  // full-height vertical, steep
    '{MODE_DRAW,  '{0, 0, 63, 63},   0, '0},  // diagonal, not steep
    '{MODE_DRAW,  '{63, 0, 0, 63},   0, '0},  // anti-diagonal, reversed order
    '{MODE_DRAW,  '{10, 20, 11, 20}, 0, '0},  // one column apart
    '{MODE_DRAW,  '{20, 10, 20, 11}, 0, '0},  // one row apart, steep
    '{MODE_DRAW,  '{5, 40, 50, 7},   0, '0},  // falling slope
    '{MODE_DRAW,  '{30, 2, 33, 60},  0, '0},  // steep, mostly vertical
    '{MODE_DRAW,  '{63, 0, 0, 1},    0, '0},  // tiny slope, reversed
    '{MODE_DRAW,  '{1, 62, 2, 0},    0, '0},  // steep, falling
    '{MODE_DRAW,  '{0, 63, 63, 62},  0, '0},
    '{MODE_DRAW,  '{42, 21, 21, 42}, 0, '0},  // alternating bit patterns
    // Count mode: one result per segment, pixel fields zero.
    '{MODE_COUNT, '{7, 7, 7, 7},     1, '{0, 0, 0, 0, 0, 0, 0, 1}},
    '{MODE_COUNT, '{0, 0, 63, 63},   1, '{0, 0, 0, 0, 0, 0, 62, 1}},
    '{MODE_COUNT, '{0, 5, 63, 5},    1, '{0, 0, 0, 0, 0, 0, 0, 1}},
    '{MODE_COUNT, '{0, 0, 63, 1},    0, '0},
    '{MODE_COUNT, '{63, 63, 0, 0},   0, '0},
    '{MODE_COUNT, '{2, 60, 9, 3},    0, '0},
    '{MODE_COUNT, '{17, 33, 42, 21}, 0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  alr_seg_if seg_bus ();
  alr_pix_if pix_bus ();

  antialiased_line_rasterizer u_top (
    .clk     (clk),
    .rst     (rst),
    .seg     (seg_bus),
    .pix     (pix_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: the mode register and what the last segment left behind.
  mode_t              steps_mode = MODE_DRAW;
  logic signed [17:0] slope_fixed = '0;
  logic signed [22:0] minor_acc = '0;
  logic [6:0]         column_counter = '0;
  logic [6:0]         end_column = '0;
  logic               axes_swapped = 1'b0;
  logic [6:0]         steps_so_far = '0;

  pix_t pending_pixels[$];
  int   failures = 0;
  bit   steady_run = 1'b0;    // no idling on either side while set
  bit   hold_request = 1'b0;  // ask the result side for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after far more than the slowest legal run needs.
  initial begin : watchdog
    #(5_000_000);
    $display("tb_antialiased_line_rasterizer: FAIL");
    $finish;
  end

  function automatic bit idle_now();
    return !steady_run && ($urandom_range(99) < 17);
  endfunction

  // Build one column: main pixel on the floor of the minor coordinate, neighbor one
  // above it. Levels share 255 by the fraction; gap_shift halves them at endpoints.
  function automatic pix_t column_pixels(longint major, longint minor, longint frac,
                                         int gap_shift, bit is_last);
    pix_t   r;
    longint main_lv;
    longint near_lv;
    main_lv = ((ONE_FX - frac) * LEVEL_MAX) >> (FRAC + gap_shift);
    near_lv = (frac * LEVEL_MAX) >> (FRAC + gap_shift);
    if (axes_swapped) begin
      r.main_x = POS_W'(minor);
      r.main_y = POS_W'(major);
      r.near_x = POS_W'(minor + 1);
      r.near_y = POS_W'(major);
    end else begin
      r.main_x = POS_W'(major);
      r.main_y = POS_W'(minor);
      r.near_x = POS_W'(major);
      r.near_y = POS_W'(minor + 1);
    end
    r.main_level = LEVEL_W'(main_lv);
    r.near_level = LEVEL_W'(near_lv);
    r.step_count = '0;
    r.last = is_last;
    return r;
  endfunction

  // Rasterize one segment the way the block should: swap axes when steep, order the
  // endpoints, round the slope toward plus infinity, then walk the interior columns.
  function automatic pix_q_t rasterize_segment(seg_t s);
    pix_q_t cols;
    pix_t   tally;
    longint xa, ya, xb, yb, tmp, dx, dy, acc, slope, fl;
    int     steps;
    xa = longint'(s.x_begin);
    ya = longint'(s.y_begin);
    xb = longint'(s.x_end);
    yb = longint'(s.y_end);
    dx = (xb > xa) ? xb - xa : xa - xb;
    dy = (yb > ya) ? yb - ya : ya - yb;
    axes_swapped = (dy > dx);
    if (axes_swapped) begin
      tmp = xa; xa = ya; ya = tmp;
      tmp = xb; xb = yb; yb = tmp;
    end
    if (xa > xb) begin
      tmp = xa; xa = xb; xb = tmp;
      tmp = ya; ya = yb; yb = tmp;
    end
    dx = xb - xa;
    dy = yb - ya;
    if (dx == 0) slope = ONE_FX;
    else if (dy >= 0) slope = (dy * ONE_FX + dx - 1) / dx;
    else slope = -((-dy * ONE_FX) / dx);
    acc = ya * ONE_FX + slope;
    steps = 0;
    if (steps_mode == MODE_DRAW) begin
      cols.push_back(column_pixels(xa, ya, 0, 1, dx <= 1));
      cols.push_back(column_pixels(xb, yb, 0, 1, dx <= 1));
    end
    for (longint col = xa + 1; col < xb; col++) begin
      fl = acc >>> FRAC;
      if (steps_mode == MODE_DRAW)
        cols.push_back(column_pixels(col, fl, acc & FRAC_MASK, 0, col + 1 == xb));
      else if (fl != ((acc + slope) >>> FRAC))
        steps++;
      acc += slope;
    end
    slope_fixed = 18'(slope);
    minor_acc = 23'(acc);
    end_column = 7'(xb);
    column_counter = 7'(xb);
    steps_so_far = 7'(steps);
    if (steps_mode == MODE_COUNT) begin
      tally = '0;
      tally.step_count = COUNT_W'(steps);
      tally.last = 1'b1;
      cols.push_back(tally);
    end
    return cols;
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  // Mostly uniform segments; some short ones to hit the one-column cases, and some
  // that are exactly horizontal or vertical.
  function automatic seg_t random_segment();
    seg_t        s;
    int unsigned pick;
    pick = $urandom_range(9);
    s.x_begin = COORD_W'($urandom_range(COORD_MAX));
    s.y_begin = COORD_W'($urandom_range(COORD_MAX));
    s.x_end = COORD_W'($urandom_range(COORD_MAX));
    s.y_end = COORD_W'($urandom_range(COORD_MAX));
    if (pick < 3) begin
      s.x_end = near_coord(s.x_begin);
      s.y_end = near_coord(s.y_begin);
    end else if (pick == 3) begin
      if ($urandom_range(1)) s.x_end = s.x_begin;
      else s.y_end = s.y_begin;
    end
    return s;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Check one transfer on the pixel channel against the oldest expectation.
  function automatic void check_pixel();
    pix_t got;
    pix_t want;
    got = {pix_bus.main_x, pix_bus.main_y, pix_bus.main_level, pix_bus.near_x,
           pix_bus.near_y, pix_bus.near_level, pix_bus.step_count, pix_bus.last};
    if (pending_pixels.size() == 0) begin
      $error("pixel transfer with nothing pending: main (%0d,%0d)", got.main_x, got.main_y);
      failures++;
    end else begin
      want = pending_pixels.pop_front();
      compare_field("main_x", 8'(want.main_x), 8'(got.main_x));
      compare_field("main_y", 8'(want.main_y), 8'(got.main_y));
      compare_field("main_level", want.main_level, got.main_level);
      compare_field("near_x", 8'(want.near_x), 8'(got.near_x));
      compare_field("near_y", 8'(want.near_y), 8'(got.near_y));
      compare_field("near_level", want.near_level, got.near_level);
      compare_field("step_count", 8'(want.step_count), 8'(got.step_count));
      compare_field("last", 8'(want.last), 8'(got.last));
    end
  endfunction

  // Offer one segment, idling at random first. Sampling right after the edge sees the
  // values that were present at the edge, so valid && ready there means a transfer.
  // Queue the expected pixels only once the segment is taken.
  task automatic send_segment(seg_t s, pix_q_t outcome);
    while (idle_now()) begin
      seg_bus.valid <= 1'b0;
      @(posedge clk);
    end
    seg_bus.valid <= 1'b1;
    seg_bus.x_begin <= s.x_begin;
    seg_bus.y_begin <= s.y_begin;
    seg_bus.x_end <= s.x_end;
    seg_bus.y_end <= s.y_end;
    @(posedge clk);
    while (!seg_bus.ready) @(posedge clk);
    foreach (outcome[i]) pending_pixels.push_back(outcome[i]);
  endtask

  // Wait until every expected pixel has been taken; the last one of a segment ends
  // the back end's work.
  task automatic drain_pixels();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the mode register over APB (setup, access), then read it back.
  task automatic write_mode(mode_t m);
    seg_bus.valid <= 1'b0;
    drain_pixels();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= APB_DATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== m) begin
      $error("count_steps_mode readback: expected %0d, got %0d", m, prdata[0]);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    steps_mode = m;
  endtask

  // Result side: check each transfer, stall at random, and hold off for one long
  // stretch when asked so that the queue fills and the segment side stalls.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    pix_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pix_bus.valid && pix_bus.ready) check_pixel();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= !idle_now();
      end
    end
  end

  initial begin : stimulus
    seg_t   s;
    pix_q_t outcome;
    int     first_mode;
    rst <= 1'b1;
    seg_bus.valid <= 1'b0;
    seg_bus.x_begin <= '0;
    seg_bus.y_begin <= '0;
    seg_bus.x_end <= '0;
    seg_bus.y_end <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; the first rows run in the mode left by reset.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].mode != steps_mode) write_mode(DIRECTED[i].mode);
      outcome = rasterize_segment(DIRECTED[i].seg);
      if (DIRECTED[i].typed_count != 0) begin
        outcome.delete();
        repeat (DIRECTED[i].typed_count) outcome.push_back(DIRECTED[i].typed);
      end
      send_segment(DIRECTED[i].seg, outcome);
    end

    // Random phases, alternating mode; rewrite the register at every phase boundary.
    first_mode = $urandom_range(1);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_mode(mode_t'((p + first_mode) % 2));
      steady_run = (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == 20) hold_request = 1'b1;
        s = random_segment();
        send_segment(s, rasterize_segment(s));
      end
    end

    // Drop valid, let everything drain, then watch for stray results.
    seg_bus.valid <= 1'b0;
    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_antialiased_line_rasterizer: PASS");
    end else begin
      $display("tb_antialiased_line_rasterizer: FAIL");
    end
    $finish;
  end

endmodule
